[rtl/core/dft_pkg.sv]
// ----------------------------------------------------------------------------
// dft_pkg: shared types and constants of the dependency file tokenizer
// Character codes, result kinds and the result bundle that travels from the
// front stage through the queue to the output stage.
// ----------------------------------------------------------------------------
package dft_pkg;

  // Character codes
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  // Result kinds
  localparam logic [1:0] KIND_PATH = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // Results per input byte and their counter widths
  localparam int MAX_RES = 4;
  localparam int RES_CW  = $clog2(MAX_RES + 1);
  localparam int RES_IW  = $clog2(MAX_RES);

  // Bundle queue geometry
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [7:0] path_byte;
    logic [1:0] kind;
  } res_t;

  typedef struct packed {
    logic [RES_CW-1:0]           cnt;
    res_t [MAX_RES-1:0]          res;
  } bundle_t;

  // Front to queue write request
  typedef struct packed {
    logic    vld;
    bundle_t data;
  } q_push_t;

  // Queue head seen by the output stage
  typedef struct packed {
    logic    vld;
    bundle_t data;
  } q_head_t;

endpackage

[rtl/core/dft_stream_if.sv]
// ----------------------------------------------------------------------------
// dft_stream_if: valid/ready channels of the dependency file tokenizer
// dft_in_if carries text bytes, dft_out_if carries path results.
// ----------------------------------------------------------------------------
interface dft_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       is_final_byte;

  modport source (output valid, output char_in, output is_final_byte, input ready);
  modport sink (input valid, input char_in, input is_final_byte, output ready);
endinterface

interface dft_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] path_byte;
  logic [1:0] kind;
  logic       run_end;

  modport source (output valid, output path_byte, output kind, output run_end,
                  input ready);
  modport sink (input valid, input path_byte, input kind, input run_end,
                output ready);
endinterface

[rtl/core/dft_front.sv]
// ----------------------------------------------------------------------------
// dft_front: byte classifier and tokenizer state
// Accepts one byte per cycle while the queue is not full, applies the
// lookahead, escape and token rules and writes its results as one queue bundle.
// ----------------------------------------------------------------------------
module dft_front (
  input  logic              clk,
  input  logic              rst_n,
  dft_in_if.sink            in_chan,
  input  logic              q_full,
  output dft_pkg::q_push_t  q_push
);

  typedef struct packed {
    logic       held_valid;
    logic [7:0] held_char;
    logic       past_colon;
    logic       token_open;
    logic       token_colon_end;
    logic       rule_done;
  } tok_st_t;

  typedef struct packed {
    tok_st_t    st;
    logic       consumed;
    logic       ev;
    logic [7:0] eb;
    logic [1:0] ek;
  } step_t;

  // Append a byte to the current token
  function automatic step_t add_byte(tok_st_t st, logic [7:0] c);
    step_t r;
    r                    = '0;
    r.st                 = st;
    r.st.token_open      = 1'b1;
    r.st.token_colon_end = (c == dft_pkg::CH_COLON);
    if (st.past_colon) begin
      r.ev = 1'b1;
      r.eb = c;
      r.ek = dft_pkg::KIND_PATH;
    end
    return r;
  endfunction

  // Close the current token: end a path, or end the target on a trailing colon
  function automatic step_t close_tok(tok_st_t st);
    step_t r;
    r    = '0;
    r.st = st;
    if (st.token_open) begin
      if (st.past_colon) begin
        r.ev = 1'b1;
        r.ek = dft_pkg::KIND_END;
      end else if (st.token_colon_end) begin
        r.st.past_colon = 1'b1;
      end
    end
    r.st.token_open      = 1'b0;
    r.st.token_colon_end = 1'b0;
    return r;
  endfunction

  // Handle byte c with lookahead nx
  function automatic step_t handle(tok_st_t st, logic [7:0] c, logic [7:0] nx);
    step_t r;
    r    = '0;
    r.st = st;
    if (c == dft_pkg::CH_BSLASH && nx == dft_pkg::CH_NL) begin
      r.consumed = 1'b1;
    end else if (c == dft_pkg::CH_BSLASH && nx == dft_pkg::CH_SPACE) begin
      r          = add_byte(st, dft_pkg::CH_SPACE);
      r.consumed = 1'b1;
    end else if (c == dft_pkg::CH_NL) begin
      r = close_tok(st);
      if (r.st.past_colon) begin
        r.st.rule_done = 1'b1;
      end
    end else if (c == dft_pkg::CH_SPACE || c == dft_pkg::CH_TAB) begin
      r = close_tok(st);
    end else if (c == dft_pkg::CH_COLON && !st.past_colon &&
                 (nx == dft_pkg::CH_SPACE || nx == dft_pkg::CH_NL ||
                  nx == dft_pkg::CH_BSLASH)) begin
      r.st.past_colon      = 1'b1;
      r.st.token_open      = 1'b0;
      r.st.token_colon_end = 1'b0;
    end else begin
      r = add_byte(st, c);
    end
    return r;
  endfunction

  tok_st_t                   st_r;
  tok_st_t                   st_nxt;
  dft_pkg::bundle_t          bundle;
  logic                      in_fire;

  assign in_chan.ready = !q_full;
  assign in_fire       = in_chan.valid && in_chan.ready;

  // Work out the next state and the results of the incoming byte
  always_comb begin
    tok_st_t                  s;
    step_t                    h;
    logic                     consumed;
    logic [dft_pkg::RES_CW-1:0] cnt;
    s        = st_r;
    h        = '0;
    consumed = 1'b0;
    cnt      = '0;
    bundle   = '0;

    if (st_r.held_valid && !st_r.rule_done) begin
      h        = handle(s, st_r.held_char, in_chan.char_in);
      s        = h.st;
      consumed = h.consumed;
      if (h.ev) begin
        bundle.res[cnt[dft_pkg::RES_IW-1:0]] = '{path_byte: h.eb, kind: h.ek};
        cnt = cnt + 1'b1;
      end
    end
    s.held_valid = 1'b0;

    if (!consumed && !s.rule_done) begin
      if (in_chan.is_final_byte) begin
        h = handle(s, in_chan.char_in, dft_pkg::CH_NL);
        s = h.st;
        if (h.ev) begin
          bundle.res[cnt[dft_pkg::RES_IW-1:0]] = '{path_byte: h.eb, kind: h.ek};
          cnt = cnt + 1'b1;
        end
      end else begin
        s.held_char  = in_chan.char_in;
        s.held_valid = 1'b1;
      end
    end

    // Last byte: close the open token, report done, restart
    if (in_chan.is_final_byte) begin
      if (!s.rule_done) begin
        h = close_tok(s);
        if (h.ev) begin
          bundle.res[cnt[dft_pkg::RES_IW-1:0]] = '{path_byte: h.eb, kind: h.ek};
          cnt = cnt + 1'b1;
        end
      end
      bundle.res[cnt[dft_pkg::RES_IW-1:0]] = '{path_byte: 8'd0,
                                               kind: dft_pkg::KIND_DONE};
      cnt = cnt + 1'b1;
      s   = '0;
    end

    bundle.cnt = cnt;
    st_nxt     = s;
  end

  // Advance the tokenizer state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  assign q_push.vld  = in_fire && (bundle.cnt != '0);
  assign q_push.data = bundle;

  // A last byte always leaves a done result behind
  a_final_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_chan.is_final_byte |-> q_push.vld)
    else $error("final byte produced no bundle");

  // After a last byte the tokenizer is back in its reset state
  a_final_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_chan.is_final_byte |=> st_r == '0)
    else $error("state not cleared after final byte");

endmodule

[rtl/core/dft_queue.sv]
// ----------------------------------------------------------------------------
// dft_queue: short bundle queue between front and output stages
// Holds up to Q_DEPTH result bundles so either side can stall on its own.
// ----------------------------------------------------------------------------
module dft_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  dft_pkg::q_push_t  q_push,
  input  logic              pop,
  output logic              q_full,
  output dft_pkg::q_head_t  q_head
);

  dft_pkg::bundle_t                mem_r [dft_pkg::Q_DEPTH];
  logic [dft_pkg::Q_AW-1:0]        wr_ptr_r;
  logic [dft_pkg::Q_AW-1:0]        rd_ptr_r;
  logic [dft_pkg::Q_CW-1:0]        cnt_r;
  logic                            do_pop;

  localparam logic [dft_pkg::Q_AW-1:0] PTR_LAST = dft_pkg::Q_AW'(dft_pkg::Q_DEPTH - 1);
  localparam logic [dft_pkg::Q_CW-1:0] CNT_FULL = dft_pkg::Q_CW'(dft_pkg::Q_DEPTH);

  assign q_full      = (cnt_r == CNT_FULL);
  assign q_head.vld  = (cnt_r != '0);
  assign q_head.data = mem_r[rd_ptr_r];
  assign do_pop      = pop && q_head.vld;

  // Store a pushed bundle
  always_ff @(posedge clk) begin
    if (q_push.vld) begin
      mem_r[wr_ptr_r] <= q_push.data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (q_push.vld) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (q_push.vld && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!q_push.vld && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.vld |-> !q_full)
    else $error("push into full bundle queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_head.vld)
    else $error("pop from empty bundle queue");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("bundle queue occupancy out of range");

endmodule

[rtl/core/dft_back.sv]
// ----------------------------------------------------------------------------
// dft_back: result serializer
// Takes one bundle from the queue at a time and delivers its results one per
// cycle while ready is high, flagging the last one of each bundle with run_end.
// ----------------------------------------------------------------------------
module dft_back (
  input  logic              clk,
  input  logic              rst_n,
  input  dft_pkg::q_head_t  q_head,
  output logic              pop,
  dft_out_if.source         out_chan
);

  dft_pkg::bundle_t              cur_r;
  logic                          cur_vld_r;
  logic [dft_pkg::RES_IW-1:0]    idx_r;
  logic                          last;
  logic                          out_fire;
  logic                          need_load;

  assign last      = (idx_r == dft_pkg::RES_IW'(cur_r.cnt - 1'b1));
  assign out_fire  = cur_vld_r && out_chan.ready;
  assign need_load = !cur_vld_r || (out_fire && last);
  assign pop       = need_load && q_head.vld;

  // Hold the current bundle and step through its results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= '0;
    end else if (need_load) begin
      cur_vld_r <= q_head.vld;
      idx_r     <= '0;
    end else if (out_fire) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= q_head.data;
    end
  end

  assign out_chan.valid     = cur_vld_r;
  assign out_chan.path_byte = cur_r.res[idx_r].path_byte;
  assign out_chan.kind      = cur_r.res[idx_r].kind;
  assign out_chan.run_end   = last;

  a_bundle_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cur_vld_r |-> (cur_r.cnt != '0))
    else $error("empty bundle in output stage");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_vld_r |-> (dft_pkg::RES_CW'(idx_r) < cur_r.cnt))
    else $error("result index past bundle end");

endmodule

[rtl/core/depfile_dependency_tokenizer_core.sv]
// ----------------------------------------------------------------------------
// depfile_dependency_tokenizer_core: make-style dependency file tokenizer
// Streams the prerequisite paths of the first rule of a dependency file.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle while the bundle queue has room and
// gives path bytes, end-of-path markers and a done marker after the byte
// flagged as last; run_end marks the final result caused by each byte. A byte
// causes zero to four results. The front stage accepts a byte every cycle
// while its four-entry bundle queue has room; the output stage delivers one
// result per cycle while the receiver is ready, so sustained rate is one byte
// per cycle while each byte yields at most one result. The results of a byte
// are written into the bundle queue and then loaded into the output stage's
// current bundle before the first is offered. Results are held until taken
// and never dropped.
module depfile_dependency_tokenizer_core (
  input  logic      clk,
  input  logic      rst_n,
  dft_in_if.sink    in_chan,
  dft_out_if.source out_chan
);

  dft_pkg::q_push_t q_push;
  dft_pkg::q_head_t q_head;
  logic             q_full;
  logic             pop;

  dft_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push)
  );

  dft_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (pop),
    .q_full (q_full),
    .q_head (q_head)
  );

  dft_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_head   (q_head),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule
